FILE: hdl/hbpq_pkg.sv
package hbpq_pkg;

   // Storage geometry and field widths
   localparam int DEPTH      = 64;
   localparam int KEY_W      = 32;
   localparam int PAYLOAD_W  = 16;
   localparam int ENTRY_W    = KEY_W + PAYLOAD_W;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int COUNT_W    = $clog2(DEPTH + 1);
   localparam int CHILD_W    = ADDR_W + 2;
   localparam int CAP_W      = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam int REQ_W      = 2;
   localparam int STATUS_W   = 2;

   localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(DEPTH);

   // Request codes
   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_PEEK   = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORDER    = 1'd1;

   typedef struct packed {
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } entry_type;

   typedef struct packed {
      logic [CAP_W-1:0] capacity_limit;
      logic             heap_order;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_READ,
      ST_UP_CMP,
      ST_TOP_READ,
      ST_TOP_WAIT,
      ST_DN_READ,
      ST_DN_LEFT,
      ST_DN_RIGHT,
      ST_PLACE,
      ST_DONE
   } state_type;

endpackage

FILE: hdl/binary_heap_priority_queue.sv
// An insert walks up from the new slot, comparing one parent at a time; a remove
// takes the top and sifts the last entry down one level at a time. A peek, or the
// remove of the last entry, reads the top only; full, empty or an unused code skips the store.
// The single key comparator and the two-read-port heap memory set the pace of each walk.
// One request at a time: the next is taken the cycle after the result
// is loaded into the output register, which holds it until the beat is taken.
// Reset (synchronous) empties the queue, sets capacity 64 and largest-key-first order.
module binary_heap_priority_queue import hbpq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [REQ_W-1:0]      req_type,
   input  logic [KEY_W-1:0]      req_in_key,
   input  logic [PAYLOAD_W-1:0]  req_in_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [KEY_W-1:0]      rsp_top_key,
   output logic [PAYLOAD_W-1:0]  rsp_top_payload,
   output logic [COUNT_W-1:0]    rsp_entry_count
);

   cfg_type cfg_ff, cfg_in;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CAPACITY: cfg_in.capacity_limit = csr_wdata[CAP_W-1:0];
            CSR_ORDER:    cfg_in.heap_order     = csr_wdata[0];
            default:      cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.capacity_limit <= CAP_W'(DEPTH);
         cfg_ff.heap_order     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hbpq_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_in_key      (req_in_key),
      .req_in_payload  (req_in_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_top_key     (rsp_top_key),
      .rsp_top_payload (rsp_top_payload),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

FILE: hdl/hbpq_ram.sv
module hbpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // One write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: hdl/hbpq_cmp.sv
module hbpq_cmp import hbpq_pkg::*; (
   input  logic [KEY_W-1:0] cand_key,
   input  logic [KEY_W-1:0] ref_key,
   input  logic             heap_order,
   output logic             wins
);

   // Candidate is served strictly before the reference key
   always_comb begin
      if (heap_order) begin
         wins = cand_key < ref_key;
      end else begin
         wins = cand_key > ref_key;
      end
   end

endmodule

FILE: hdl/hbpq_seq.sv
module hbpq_seq import hbpq_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [REQ_W-1:0]     req_type,
   input  logic [KEY_W-1:0]     req_in_key,
   input  logic [PAYLOAD_W-1:0] req_in_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [KEY_W-1:0]     rsp_top_key,
   output logic [PAYLOAD_W-1:0] rsp_top_payload,
   output logic [COUNT_W-1:0]   rsp_entry_count
);

   state_type              state_ff, state_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [ADDR_W-1:0]      pos_ff, pos_in;
   entry_type              mov_ff, mov_in;
   entry_type              best_ff, best_in;
   logic                   best_child_ff, best_child_in;
   logic                   remove_ff, remove_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   entry_type              top_ff, top_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   entry_type              rsp_top_ff, rsp_top_in;
   logic [COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [ENTRY_W-1:0]     wr_data;
   logic [ADDR_W-1:0]      rd_addr_a;
   logic [ADDR_W-1:0]      rd_addr_b;
   logic [ENTRY_W-1:0]     rd_data_a;
   logic [ENTRY_W-1:0]     rd_data_b;
   entry_type              rd_a;
   entry_type              rd_b;

   logic [KEY_W-1:0]       cmp_cand;
   logic [KEY_W-1:0]       cmp_ref;
   logic                   cmp_wins;

   logic [COUNT_W-1:0]     limit;
   logic [ADDR_W-1:0]      parent;
   logic [ADDR_W-1:0]      last_idx;
   logic [CHILD_W-1:0]     left_idx;
   logic [CHILD_W-1:0]     right_idx;
   logic [CHILD_W-1:0]     count_ext;

   hbpq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   hbpq_cmp u_cmp (
      .cand_key   (cmp_cand),
      .ref_key    (cmp_ref),
      .heap_order (cfg.heap_order),
      .wins       (cmp_wins)
   );

   assign rd_a = entry_type'(rd_data_a);
   assign rd_b = entry_type'(rd_data_b);

   // Index arithmetic for the heap walk
   assign parent    = ADDR_W'((pos_ff - 1'b1) >> 1);
   assign last_idx  = ADDR_W'(count_ff - 1'b1);
   assign left_idx  = {1'b0, pos_ff, 1'b1};
   assign right_idx = left_idx + 1'b1;
   assign count_ext = CHILD_W'(count_ff);

   // Saturate the capacity register to the store depth
   always_comb begin
      if (int'(cfg.capacity_limit) > DEPTH) begin
         limit = DEPTH_COUNT;
      end else begin
         limit = COUNT_W'(cfg.capacity_limit);
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   // Sequencer: next state, store access and comparator operands
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      mov_in        = mov_ff;
      best_in       = best_ff;
      best_child_in = best_child_ff;
      remove_in     = remove_ff;
      status_in     = status_ff;
      top_in        = top_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = mov_ff;
      rd_addr_a     = '0;
      rd_addr_b     = '0;
      cmp_cand      = mov_ff.key;
      cmp_ref       = rd_a.key;

      // Drop the result beat once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               status_in = STAT_OK;
               top_in    = '0;
               remove_in = (req_type == REQ_REMOVE);
               case (req_type)
                  REQ_INSERT: begin
                     if (count_ff >= limit) begin
                        status_in = STAT_FULL;
                        state_in  = ST_DONE;
                     end else begin
                        mov_in.key     = req_in_key;
                        mov_in.payload = req_in_payload;
                        pos_in         = ADDR_W'(count_ff);
                        count_in       = count_ff + 1'b1;
                        if (count_ff == '0) begin
                           state_in = ST_PLACE;
                        end else begin
                           state_in = ST_UP_READ;
                        end
                     end
                  end
                  REQ_REMOVE, REQ_PEEK: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_TOP_READ;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_UP_READ: begin
            rd_addr_a = parent;
            state_in  = ST_UP_CMP;
         end
         ST_UP_CMP: begin
            // Move the parent down while the new entry beats it
            rd_addr_a = parent;
            cmp_cand  = mov_ff.key;
            cmp_ref   = rd_a.key;
            if (cmp_wins) begin
               wr_en   = 1'b1;
               wr_data = rd_data_a;
               pos_in  = parent;
               if (parent == '0) begin
                  state_in = ST_PLACE;
               end else begin
                  state_in = ST_UP_READ;
               end
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_TOP_READ: begin
            rd_addr_a = '0;
            rd_addr_b = last_idx;
            state_in  = ST_TOP_WAIT;
         end
         ST_TOP_WAIT: begin
            // Capture the top; the last entry becomes the one to sift down
            top_in = rd_a;
            mov_in = rd_b;
            pos_in = '0;
            if (remove_ff) begin
               count_in = count_ff - 1'b1;
               if (count_ff == COUNT_W'(1)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_DN_READ;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DN_READ: begin
            rd_addr_a = ADDR_W'(left_idx);
            rd_addr_b = ADDR_W'(right_idx);
            if (left_idx >= count_ext) begin
               state_in = ST_PLACE;
            end else begin
               state_in = ST_DN_LEFT;
            end
         end
         ST_DN_LEFT: begin
            rd_addr_a     = ADDR_W'(left_idx);
            rd_addr_b     = ADDR_W'(right_idx);
            cmp_cand      = rd_a.key;
            cmp_ref       = mov_ff.key;
            best_child_in = cmp_wins;
            if (cmp_wins) begin
               best_in = rd_a;
            end else begin
               best_in = mov_ff;
            end
            state_in = ST_DN_RIGHT;
         end
         ST_DN_RIGHT: begin
            // Pull the better child up into the hole, or stop here
            rd_addr_a = ADDR_W'(left_idx);
            rd_addr_b = ADDR_W'(right_idx);
            cmp_cand  = rd_b.key;
            cmp_ref   = best_ff.key;
            if ((right_idx < count_ext) && cmp_wins) begin
               wr_en    = 1'b1;
               wr_data  = rd_data_b;
               pos_in   = ADDR_W'(right_idx);
               state_in = ST_DN_READ;
            end else if (best_child_ff) begin
               wr_en    = 1'b1;
               wr_data  = best_ff;
               pos_in   = ADDR_W'(left_idx);
               state_in = ST_DN_READ;
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            wr_en    = 1'b1;
            wr_data  = mov_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hand the result to the output register when it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_top_in    = top_ff;
               rsp_count_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      mov_ff        <= mov_in;
      best_ff       <= best_in;
      best_child_ff <= best_child_in;
      remove_ff     <= remove_in;
      status_ff     <= status_in;
      top_ff        <= top_in;
      rsp_status_ff <= rsp_status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_top_key     = rsp_top_ff.key;
   assign rsp_top_payload = rsp_top_ff.payload;
   assign rsp_entry_count = rsp_count_ff;

endmodule
